// ===== sv/midpoint_line_rasterizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit_defines
// assertion macros for the line rasterizer, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define MLR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled in reset
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MLR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// shared widths and controller/datapath interface types
// ----------------------------------------------------------------------------
package mlr_pkg;

  // fixed width of every coordinate port
  localparam int PIX_W = 6;
  // default coordinate width used inside the walk
  localparam int COORD_BITS_DEF = 6;

  typedef struct packed {
    logic load;   // latch a new segment
    logic step;   // advance to the next pixel
  } mlr_cmd_t;

  typedef struct packed {
    logic last;   // current pixel is the final one
  } mlr_sts_t;

endpackage

// ===== sv/mlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlr_ctrl
// controller: idle / walk sequencing and channel handshakes
// ----------------------------------------------------------------------------
module mlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mlr_pkg::mlr_sts_t sts,
  output mlr_pkg::mlr_cmd_t cmd
);
  import mlr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_take;

  assign out_valid = (state_r == ST_WALK);
  assign out_take  = out_valid && out_ready;
  // a new segment may enter as the final pixel leaves
  assign in_ready  = (state_r == ST_IDLE) || (out_take && sts.last);

  assign cmd.load = in_valid && in_ready;
  assign cmd.step = out_take && !sts.last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (cmd.load) state_nxt = ST_WALK;
        else if (out_take && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/mlr_dp.sv =====
// ----------------------------------------------------------------------------
// mlr_dp
// datapath: segment setup, decision variable and pixel position registers
// ----------------------------------------------------------------------------
module mlr_dp #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic [mlr_pkg::PIX_W-1:0] in_start_x,
  input  logic [mlr_pkg::PIX_W-1:0] in_start_y,
  input  logic [mlr_pkg::PIX_W-1:0] in_end_x,
  input  logic [mlr_pkg::PIX_W-1:0] in_end_y,
  input  mlr_pkg::mlr_cmd_t         cmd,
  output mlr_pkg::mlr_sts_t         sts,
  output logic [mlr_pkg::PIX_W-1:0] out_pixel_x,
  output logic [mlr_pkg::PIX_W-1:0] out_pixel_y,
  output logic                      out_last_pixel
);
  import mlr_pkg::*;

  localparam int CW = COORD_BITS;
  // decision variable spans -2*(2^CW-1) .. 2*(2^CW-1)
  localparam int DW = COORD_BITS + 2;

  logic [CW-1:0] ax, ay, bx, by;
  logic [CW-1:0] x0, y0, xe, ye;
  logic [CW-1:0] spanx, spany, len, mnr;
  logic          swap, ydown, ymaj;
  logic signed [DW-1:0] d_init;

  logic [CW-1:0] x_r, x_nxt, y_r, y_nxt, cnt_r, cnt_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic [CW:0]   two_m_r, two_m_nxt, two_lm_r, two_lm_nxt;
  logic          ymaj_r, ymaj_nxt, ydown_r, ydown_nxt;
  logic          diag;
  logic [CW-1:0] y_step;

  // setup: order endpoints so x rises, then pick the major axis
  assign ax = in_start_x[CW-1:0];
  assign ay = in_start_y[CW-1:0];
  assign bx = in_end_x[CW-1:0];
  assign by = in_end_y[CW-1:0];

  assign swap  = (bx < ax);
  assign x0    = swap ? bx : ax;
  assign y0    = swap ? by : ay;
  assign xe    = swap ? ax : bx;
  assign ye    = swap ? ay : by;
  assign spanx = xe - x0;
  assign ydown = (ye < y0);
  assign spany = ydown ? (y0 - ye) : (ye - y0);
  assign ymaj  = (spany > spanx);
  assign len   = ymaj ? spany : spanx;
  assign mnr   = ymaj ? spanx : spany;
  assign d_init = $signed({2'b00, len}) - $signed({1'b0, mnr, 1'b0});

  // walk step
  assign diag   = d_r[DW-1] || (d_r == '0);
  assign y_step = ydown_r ? (y_r - CW'(1)) : (y_r + CW'(1));

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    cnt_nxt    = cnt_r;
    d_nxt      = d_r;
    two_m_nxt  = two_m_r;
    two_lm_nxt = two_lm_r;
    ymaj_nxt   = ymaj_r;
    ydown_nxt  = ydown_r;
    if (cmd.load) begin
      x_nxt      = x0;
      y_nxt      = y0;
      cnt_nxt    = len;
      d_nxt      = d_init;
      two_m_nxt  = {mnr, 1'b0};
      two_lm_nxt = {len - mnr, 1'b0};
      ymaj_nxt   = ymaj;
      ydown_nxt  = ydown;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - CW'(1);
      if (diag) d_nxt = d_r + $signed({1'b0, two_lm_r});
      else      d_nxt = d_r - $signed({1'b0, two_m_r});
      if (ymaj_r) begin
        y_nxt = y_step;
        if (diag) x_nxt = x_r + CW'(1);
      end else begin
        x_nxt = x_r + CW'(1);
        if (diag) y_nxt = y_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cnt_r    <= cnt_nxt;
    d_r      <= d_nxt;
    two_m_r  <= two_m_nxt;
    two_lm_r <= two_lm_nxt;
    ymaj_r   <= ymaj_nxt;
    ydown_r  <= ydown_nxt;
  end

  assign sts.last       = (cnt_r == '0);
  assign out_pixel_x    = PIX_W'(x_r);
  assign out_pixel_y    = PIX_W'(y_r);
  assign out_last_pixel = sts.last;

endmodule

// ===== sv/midpoint_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit
// midpoint line walk over a tile: one segment in, its pixels out in order
//
//   channel  direction  payload                                 transaction
//   in       input      start_x, start_y, end_x, end_y          one segment
//   out      output     pixel_x, pixel_y, last_pixel            one pixel
//
// a segment with major span L gives L+1 pixels, one per cycle while out_ready
// is high; the decision variable register and step counter set this pace
// a segment is loaded as it is taken; the next one is taken as the final pixel
// of the current segment leaves, so back-to-back segments run with no gap
// out_ready low holds the current pixel; reset returns the controller to idle
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_unit_defines.svh"

module midpoint_line_rasterizer_unit #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mlr_pkg::PIX_W-1:0] in_start_x,
  input  logic [mlr_pkg::PIX_W-1:0] in_start_y,
  input  logic [mlr_pkg::PIX_W-1:0] in_end_x,
  input  logic [mlr_pkg::PIX_W-1:0] in_end_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mlr_pkg::PIX_W-1:0] out_pixel_x,
  output logic [mlr_pkg::PIX_W-1:0] out_pixel_y,
  output logic                      out_last_pixel
);
  import mlr_pkg::*;

  mlr_cmd_t cmd;
  mlr_sts_t sts;

  mlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .cmd            (cmd),
    .sts            (sts),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  // a loaded segment always shows its first pixel next cycle
  `MLR_ASSERT_NEXT(a_load_shows_pixel, clk, rst_n, in_valid && in_ready, out_valid)
  // a new segment only enters while idle or as the final pixel is taken
  `MLR_ASSERT_IMPL(a_enter_on_last, clk, rst_n, in_ready && out_valid, out_ready && out_last_pixel)
  // taking a pixel that is not the last keeps the walk going
  `MLR_ASSERT_NEXT(a_walk_continues, clk, rst_n, out_valid && out_ready && !out_last_pixel, out_valid)
  // the final pixel with no new segment drops the output
  `MLR_ASSERT_NEXT(a_walk_ends, clk, rst_n, out_valid && out_ready && out_last_pixel && !in_valid, !out_valid)

endmodule

// ===== tb/sv/midpoint_line_rasterizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit_tb
// checks the pixel walk of every segment against a midpoint line predictor
//
// segments go in over the valid/ready input channel; a scoreboard expands each
// accepted segment into its pixels and compares every pixel that leaves the
// output channel, in order, field by field. directed segments cover the
// corners, x-major and y-major slopes in both y directions, ties and zero
// length; random segments follow, with random stalls on both sides, a long output hold-off and a full drain
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlr_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 20;
  localparam int COORD_MAX    = (1 << PIX_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t expected_q[$];
    int     error_count;

    function new();
      error_count = 0;
    endfunction

    function void report_mismatch(string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // expand one segment into its pixels, walking with x rising
    function void note_segment(input logic [PIX_W-1:0] sx, sy, ex, ey);
      int     mask, x, y, x_stop, y_stop, span_x, span_y, y_step;
      int     major, minor, d;
      bit     y_major, diag;
      pixel_t px;
      mask = (1 << COORD_BITS_DEF) - 1;
      if ((int'(ex) & mask) < (int'(sx) & mask)) begin
        x      = int'(ex) & mask;
        y      = int'(ey) & mask;
        x_stop = int'(sx) & mask;
        y_stop = int'(sy) & mask;
      end else begin
        x      = int'(sx) & mask;
        y      = int'(sy) & mask;
        x_stop = int'(ex) & mask;
        y_stop = int'(ey) & mask;
      end
      span_x = x_stop - x;
      if (y_stop >= y) begin
        span_y = y_stop - y;
        y_step = 1;
      end else begin
        span_y = y - y_stop;
        y_step = -1;
      end
      y_major = span_y > span_x;
      major   = y_major ? span_y : span_x;
      minor   = y_major ? span_x : span_y;
      d       = major - 2 * minor;
      for (int k = 0; k <= major; k++) begin
        if (k > 0) begin
          // a tie (d == 0) takes the diagonal step
          diag = (d <= 0);
          if (diag) d += 2 * (major - minor);
          else d -= 2 * minor;
          if (y_major) begin
            y += y_step;
            if (diag) x += 1;
          end else begin
            x += 1;
            if (diag) y += y_step;
          end
        end
        px.x    = x[PIX_W-1:0];
        px.y    = y[PIX_W-1:0];
        px.last = (k == major);
        expected_q.insert(expected_q.size(), px);
      end
    endfunction

    function void check_pixel(input logic [PIX_W-1:0] x, y, input logic last);
      pixel_t px;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with no segment pending", x, y));
        return;
      end
      px = expected_q.pop_front();
      if (x !== px.x)
        report_mismatch($sformatf("pixel_x %0d, expected %0d", x, px.x));
      if (y !== px.y)
        report_mismatch($sformatf("pixel_y %0d, expected %0d", y, px.y));
      if (last !== px.last)
        report_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                  last, px.last, px.x, px.y));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] in_start_x;
  logic [PIX_W-1:0] in_start_y;
  logic [PIX_W-1:0] in_end_x;
  logic [PIX_W-1:0] in_end_y;
  logic             out_valid;
  logic             out_ready;
  logic [PIX_W-1:0] out_pixel_x;
  logic [PIX_W-1:0] out_pixel_y;
  logic             out_last_pixel;

  bit               calm = 1'b0;
  bit               hold_req = 1'b0;
  int               quiet_cycles = 0;
  pixel_scoreboard  pixel_sb;

  midpoint_line_rasterizer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // sample both channels before the edge updates anything
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pixel_sb.note_segment(in_start_x, in_start_y, in_end_x, in_end_y);
      if (out_valid && out_ready)
        pixel_sb.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** midpoint_line_rasterizer_unit: FAILED **");
      $finish;
    end
  end

  // pixel receiver: random stalls, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = calm || ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic send_segment(input logic [PIX_W-1:0] sx, sy, ex, ey);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid = 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_start_x = sx;
    in_start_y = sy;
    in_end_x   = ex;
    in_end_y   = ey;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random_segment();
    logic [PIX_W-1:0] sx, sy, ex, ey;
    int pick, lo, hi, len;
    pick = $urandom_range(99);
    sx = PIX_W'($urandom_range(COORD_MAX));
    sy = PIX_W'($urandom_range(COORD_MAX));
    ex = PIX_W'($urandom_range(COORD_MAX));
    ey = PIX_W'($urandom_range(COORD_MAX));
    if (pick < 20) begin
      // short segment around the start point
      lo = (sx < 3) ? 0 : sx - 3;
      hi = (sx > COORD_MAX - 3) ? COORD_MAX : sx + 3;
      ex = PIX_W'($urandom_range(hi, lo));
      lo = (sy < 3) ? 0 : sy - 3;
      hi = (sy > COORD_MAX - 3) ? COORD_MAX : sy + 3;
      ey = PIX_W'($urandom_range(hi, lo));
    end else if (pick < 30) begin
      case ($urandom_range(3))
        0: begin
          ex = sx;
          ey = sy;
        end
        1: ey = sy;
        2: ex = sx;
        default: begin
          // pure diagonal, either y direction
          if ($urandom_range(1)) begin
            len = (COORD_MAX - sx < COORD_MAX - sy) ? COORD_MAX - sx : COORD_MAX - sy;
            len = $urandom_range(len);
            ey = PIX_W'(sy + len);
          end else begin
            len = (COORD_MAX - sx < sy) ? COORD_MAX - sx : sy;
            len = $urandom_range(len);
            ey = PIX_W'(sy - len);
          end
          ex = PIX_W'(sx + len);
        end
      endcase
    end
    send_segment(sx, sy, ex, ey);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    pixel_sb   = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x   = '0;
    in_end_y   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero length, at both corners
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    // axis aligned, both directions
    send_segment(0, 0, 63, 0);
    send_segment(63, 5, 0, 5);
    send_segment(10, 0, 10, 63);
    send_segment(10, 63, 10, 0);
    // full diagonals in all four directions
    send_segment(0, 0, 63, 63);
    send_segment(63, 0, 0, 63);
    send_segment(0, 63, 63, 0);
    send_segment(63, 63, 0, 0);
    // x-major and y-major, y rising and falling, with swapped endpoints
    send_segment(0, 0, 63, 20);
    send_segment(0, 40, 63, 10);
    send_segment(63, 20, 0, 0);
    send_segment(5, 0, 20, 63);
    send_segment(5, 63, 20, 0);
    send_segment(20, 63, 5, 0);
    // decision ties
    send_segment(0, 0, 4, 2);
    send_segment(0, 0, 2, 4);
    send_segment(4, 2, 0, 4);
    // unit steps and alternating bit patterns
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 0, 1);
    send_segment(1, 1, 0, 0);
    send_segment(21, 42, 42, 21);
    send_segment(42, 21, 21, 42);

    repeat (40) send_random_segment();

    // output held off while segments keep coming, so the input stalls
    hold_req = 1'b1;
    repeat (8) send_random_segment();

    release_input();
    wait_drained();

    calm = 1'b1;
    repeat (30) send_random_segment();
    calm = 1'b0;
    repeat (32) send_random_segment();

    release_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_sb.pending() != 0)
      pixel_sb.report_mismatch($sformatf("%0d pixels never emitted", pixel_sb.pending()));

    if (pixel_sb.error_count == 0) begin
      $display("** midpoint_line_rasterizer_unit: PASSED **");
    end else begin
      $display("** midpoint_line_rasterizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
